>>> sv/json_prompt_field_extractor_assert.svh
// Assertion macros used by the checker file.
`ifndef JSON_PROMPT_FIELD_EXTRACTOR_ASSERT_SVH
`define JSON_PROMPT_FIELD_EXTRACTOR_ASSERT_SVH

// Checked at every edge, outside reset.
`define JPFE_ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define JPFE_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> sv/jpfe_pkg.sv
`default_nettype none
package jpfe_pkg;

  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = 2;

  localparam logic [1:0] KIND_CHAR = 2'd0;
  localparam logic [1:0] KIND_OK   = 2'd1;
  localparam logic [1:0] KIND_ERR  = 2'd2;

  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_BSL   = 8'h5c;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_COLON = 8'h3a;
  localparam logic [7:0] CH_LF    = 8'h0a;
  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_N     = 8'h6e;
  localparam logic [7:0] CH_T     = 8'h74;
  localparam logic [7:0] CH_R     = 8'h72;

  localparam logic [15:0] CAP_RESET = 16'd255;

  typedef enum logic [2:0] {
    PH_SEARCH = 3'd0,
    PH_SKIP   = 3'd1,
    PH_VALUE  = 3'd2,
    PH_ESCAPE = 3'd3,
    PH_DONE   = 3'd4
  } phase_t;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       text_end;
  } in_beat_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] value_byte;
    logic       final_res;
  } out_beat_t;

  typedef struct packed {
    logic       has_char;
    logic [7:0] ch;
    logic       has_stat;
    logic       stat_err;
  } job_t;

  function automatic logic [7:0] key_byte(input logic [2:0] idx);
    logic [7:0] b;
    unique case (idx)
      3'd0:    b = CH_QUOTE;
      3'd1:    b = 8'h70;
      3'd2:    b = 8'h72;
      3'd3:    b = 8'h6f;
      3'd4:    b = 8'h6d;
      3'd5:    b = 8'h70;
      3'd6:    b = 8'h74;
      default: b = CH_QUOTE;
    endcase
    return b;
  endfunction

endpackage
`default_nettype wire

>>> sv/jpfe_front.sv
`default_nettype none
module jpfe_front import jpfe_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire in_beat_t    in_beat,
  input  wire logic        cfg_we,
  input  wire logic [15:0] cfg_data,
  input  wire logic        q_full,
  output logic             q_push,
  output job_t             q_job
);

  phase_t      phase_r, phase_nxt;
  logic [2:0]  kc_r, kc_nxt;
  logic [15:0] ce_r, ce_nxt;
  logic [15:0] cap_r;
  logic [15:0] ce_inc;
  logic        accept;
  logic        emit;
  logic [7:0]  emit_ch;
  logic [7:0]  b;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign b        = in_beat.text_byte;
  assign ce_inc   = ce_r + 16'd1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_SEARCH;
      kc_r    <= 3'd0;
      ce_r    <= 16'd0;
      cap_r   <= CAP_RESET;
    end else begin
      if (accept) begin
        phase_r <= phase_nxt;
        kc_r    <= kc_nxt;
        ce_r    <= ce_nxt;
      end
      if (cfg_we) begin
        cap_r <= cfg_data;
      end
    end
  end

  always_comb begin
    phase_nxt = phase_r;
    kc_nxt    = kc_r;
    ce_nxt    = ce_r;
    emit      = 1'b0;
    emit_ch   = 8'h00;
    q_job     = '0;
    unique case (phase_r)
      PH_SEARCH: begin
        if (b == key_byte(kc_r)) begin
          if (kc_r == 3'd7) begin
            kc_nxt    = 3'd0;
            phase_nxt = PH_SKIP;
          end else begin
            kc_nxt = kc_r + 3'd1;
          end
        end else begin
          kc_nxt = (b == CH_QUOTE) ? 3'd1 : 3'd0;
        end
      end
      PH_SKIP: begin
        priority if (b == CH_SPACE || b == CH_TAB || b == CH_COLON) begin
          phase_nxt = PH_SKIP;
        end else if (b == CH_QUOTE) begin
          phase_nxt = PH_VALUE;
          ce_nxt    = 16'd0;
          if (cap_r == 16'd0) begin
            q_job.has_stat = 1'b1;
            phase_nxt      = PH_DONE;
          end
        end else begin
          phase_nxt = PH_SEARCH;
          kc_nxt    = 3'd0;
        end
      end
      PH_VALUE: begin
        priority if (b == CH_QUOTE) begin
          q_job.has_stat = 1'b1;
          phase_nxt      = PH_DONE;
        end else if (b == CH_BSL) begin
          phase_nxt = PH_ESCAPE;
        end else begin
          emit    = 1'b1;
          emit_ch = b;
        end
      end
      PH_ESCAPE: begin
        phase_nxt = PH_VALUE;
        priority if (b == CH_N) begin
          emit    = 1'b1;
          emit_ch = CH_LF;
        end else if (b == CH_T) begin
          emit    = 1'b1;
          emit_ch = CH_TAB;
        end else if (b == CH_R) begin
          emit    = 1'b1;
          emit_ch = CH_CR;
        end else if (b == CH_BSL || b == CH_QUOTE) begin
          emit    = 1'b1;
          emit_ch = b;
        end else begin
          q_job.has_stat = 1'b1;
          q_job.stat_err = 1'b1;
          phase_nxt      = PH_DONE;
        end
      end
      PH_DONE: begin
        phase_nxt = PH_DONE;
      end
      default: begin
        phase_nxt = PH_DONE;
      end
    endcase

    if (emit) begin
      q_job.has_char = 1'b1;
      q_job.ch       = emit_ch;
      ce_nxt         = ce_inc;
      if (ce_inc >= cap_r) begin
        q_job.has_stat = 1'b1;
        phase_nxt      = PH_DONE;
      end
    end

    if (in_beat.text_end) begin
      if (phase_nxt == PH_SEARCH || phase_nxt == PH_SKIP) begin
        q_job.has_stat = 1'b1;
        q_job.stat_err = 1'b1;
      end else if (phase_nxt == PH_VALUE || phase_nxt == PH_ESCAPE) begin
        q_job.has_stat = 1'b1;
      end
      phase_nxt = PH_SEARCH;
      kc_nxt    = 3'd0;
      ce_nxt    = 16'd0;
    end

    q_push = accept && (q_job.has_char || q_job.has_stat);
  end

endmodule
`default_nettype wire

>>> sv/jpfe_queue.sv
`default_nettype none
module jpfe_queue import jpfe_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  wire job_t push_job,
  output logic      full,
  input  wire logic pop,
  output logic      head_valid,
  output job_t      head_job
);

  job_t            slot_r [Q_DEPTH];
  logic [Q_AW:0]   wr_ptr_r, wr_ptr_nxt;
  logic [Q_AW:0]   rd_ptr_r, rd_ptr_nxt;

  assign full = (wr_ptr_r[Q_AW] != rd_ptr_r[Q_AW]) &&
                (wr_ptr_r[Q_AW-1:0] == rd_ptr_r[Q_AW-1:0]);
  assign head_valid = (wr_ptr_r != rd_ptr_r);
  assign head_job   = slot_r[rd_ptr_r[Q_AW-1:0]];

  assign wr_ptr_nxt = wr_ptr_r + {{Q_AW{1'b0}}, 1'b1};
  assign rd_ptr_nxt = rd_ptr_r + {{Q_AW{1'b0}}, 1'b1};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
    end else begin
      if (push && !full) begin
        wr_ptr_r <= wr_ptr_nxt;
      end
      if (pop && head_valid) begin
        rd_ptr_r <= rd_ptr_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push && !full) begin
      slot_r[wr_ptr_r[Q_AW-1:0]] <= push_job;
    end
  end

endmodule
`default_nettype wire

>>> sv/jpfe_back.sv
`default_nettype none
module jpfe_back import jpfe_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic head_valid,
  input  wire job_t head_job,
  output logic      pop,
  output logic      out_valid,
  input  wire logic out_ready,
  output out_beat_t out_beat
);

  logic      out_valid_r, out_valid_nxt;
  out_beat_t out_beat_r, out_beat_nxt;
  logic      char_done_r, char_done_nxt;
  logic      load;

  assign out_valid = out_valid_r;
  assign out_beat  = out_beat_r;
  assign load      = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      char_done_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      char_done_r <= char_done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_beat_r <= out_beat_nxt;
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_beat_nxt  = out_beat_r;
    char_done_nxt = char_done_r;
    pop           = 1'b0;
    if (load) begin
      out_valid_nxt = head_valid;
      if (head_valid) begin
        if (head_job.has_char && !char_done_r) begin
          out_beat_nxt.kind       = KIND_CHAR;
          out_beat_nxt.value_byte = head_job.ch;
          out_beat_nxt.final_res  = 1'b0;
          if (head_job.has_stat) begin
            char_done_nxt = 1'b1;
          end else begin
            pop = 1'b1;
          end
        end else begin
          out_beat_nxt.kind       = head_job.stat_err ? KIND_ERR : KIND_OK;
          out_beat_nxt.value_byte = 8'h00;
          out_beat_nxt.final_res  = 1'b1;
          char_done_nxt           = 1'b0;
          pop                     = 1'b1;
        end
      end
    end
  end

endmodule
`default_nettype wire

>>> sv/json_prompt_field_extractor.sv
// Extracts the string value of the key "prompt" from a JSON text.
// Input channel: one text byte per beat on in_valid/in_ready, with
// in_beat.text_end set on the last byte of each text.
// Output channel: out_valid/out_ready beats carry decoded value characters
// (kind 0) and one closing status per text (kind 1 ok, kind 2 error), the
// status flagged by final_res.
// Configuration: cfg_we writes cfg_data into the capacity register, the
// largest number of characters emitted for one value; it resets to 255.
// A byte is taken in every cycle while the four-entry job queue between
// the byte classifier and the result emitter has room. The first result
// of a byte passes through the queue slot and then the output register.
// One byte may give a character and a status, which the emitter sends as
// two beats, character first, one beat a cycle while out_ready is high.
// When the receiver stalls, the output register holds its beat, the queue
// fills and in_ready falls once it is full.
// Synchronous reset empties the queue and the output register and returns
// the search to the start of a new text.
`default_nettype none
module json_prompt_field_extractor import jpfe_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire in_beat_t    in_beat,
  output logic             out_valid,
  input  wire logic        out_ready,
  output out_beat_t        out_beat,
  input  wire logic        cfg_we,
  input  wire logic [15:0] cfg_data
);

  logic q_full;
  logic q_push;
  job_t q_job;
  logic q_pop;
  logic q_head_valid;
  job_t q_head_job;

  jpfe_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_beat  (in_beat),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_job    (q_job)
  );

  jpfe_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_job   (q_job),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_head_valid),
    .head_job   (q_head_job)
  );

  jpfe_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (q_head_valid),
    .head_job   (q_head_job),
    .pop        (q_pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_beat   (out_beat)
  );

endmodule
`default_nettype wire

>>> sv/jpfe_checker.sv
`default_nettype none
`include "json_prompt_field_extractor_assert.svh"
module jpfe_checker import jpfe_pkg::*; (
  input wire logic      clk,
  input wire logic      rst_n,
  input wire logic      out_valid,
  input wire logic      out_ready,
  input wire out_beat_t out_beat
);

  logic stall_w;
  logic char_w;
  logic stat_w;
  logic stat_ok;

  assign stall_w = out_valid && !out_ready;
  assign char_w  = out_valid && out_beat.kind == KIND_CHAR;
  assign stat_w  = out_valid && out_beat.kind != KIND_CHAR;
  assign stat_ok = out_beat.final_res && out_beat.value_byte == 8'h00 &&
                   (out_beat.kind == KIND_OK || out_beat.kind == KIND_ERR);

  `JPFE_ASSERT_ALWAYS(a_reset_empty, !rst_n |=> !out_valid, "output valid after reset")
  `JPFE_ASSERT_CLK(a_hold, stall_w |=> out_valid && $stable(out_beat), "stalled beat changed")
  `JPFE_ASSERT_CLK(a_char_beat, char_w |-> !out_beat.final_res, "character beat marked final")
  `JPFE_ASSERT_CLK(a_status_beat, stat_w |-> stat_ok, "malformed status beat")

endmodule

bind json_prompt_field_extractor jpfe_checker u_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_beat  (out_beat)
);
`default_nettype wire
